// ----- rtl/vxlan_decap_header_parser_defines.svh -----
// Assertion macros shared by the VXLAN decapsulation header parser.
`ifndef VXLAN_DECAP_HEADER_PARSER_DEFINES_SVH
`define VXLAN_DECAP_HEADER_PARSER_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define VXDP_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define VXDP_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/vxdp_pkg.sv -----
// Package with types and constants of the VXLAN decapsulation header parser.
package vxdp_pkg;

  localparam int unsigned MAX_VLAN_TAGS = 2;

  localparam logic [15:0] VXLAN_PORT_RESET = 16'd4789;
  localparam logic [15:0] ETYPE_CVLAN      = 16'h8100;
  localparam logic [15:0] ETYPE_SVLAN      = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV4       = 16'h0800;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;

  localparam logic [4:0] ETH_HDR_SIZE   = 5'd14;
  localparam logic [6:0] IPV4_HDR_SIZE  = 7'd20;
  localparam logic [6:0] UDP_HDR_SIZE   = 7'd8;
  localparam logic [6:0] VXLAN_HDR_SIZE = 7'd8;

  typedef struct packed {
    logic       verdict;
    logic       is_vxlan;
    logic [5:0] strip_length;
  } result_t;

endpackage

// ----- rtl/vxdp_if.sv -----
// Handshake interfaces for the byte input channel and the result channel.
interface vxdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_byte;

  modport source (output valid, output packet_byte, output last_byte, input ready);
  modport sink (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface vxdp_out_if;
  logic       valid;
  logic       ready;
  logic       verdict;
  logic       is_vxlan;
  logic [5:0] strip_length;

  modport source (output valid, output verdict, output is_vxlan, output strip_length,
                  input ready);
  modport sink (input valid, input verdict, input is_vxlan, input strip_length,
                output ready);
endinterface

// ----- rtl/vxdp_parse.sv -----
// Input register and per-byte header parser that decides each frame at its last byte.
module vxdp_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  input  logic [15:0]       vxlan_port_i,
  input  logic              out_free_i,
  output logic              res_valid_o,
  output vxdp_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    PH_ETH,
    PH_IP,
    PH_UDP,
    PH_VXLAN,
    PH_OTHER,
    PH_VXLAN_OK
  } phase_e;

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic        s1_fire;

  logic [5:0]  byte_index_q, byte_index_d;
  logic [1:0]  tag_count_q, tag_count_d;
  logic [15:0] ether_type_q, ether_type_d;
  logic [4:0]  ip_start_q, ip_start_d;
  logic [7:0]  ip_proto_q, ip_proto_d;
  logic [15:0] dest_port_q, dest_port_d;
  phase_e      phase_q, phase_d;

  logic [6:0]  pos;
  logic [6:0]  ip_base;
  logic [6:0]  udp_base;
  logic [6:0]  strip_full;
  logic [15:0] et_full;

  assign s1_fire    = s1_valid_q && (!s1_last_q || out_free_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  assign pos        = {1'b0, byte_index_q};
  assign ip_base    = {2'b00, ip_start_q};
  assign udp_base   = ip_base + vxdp_pkg::IPV4_HDR_SIZE;
  assign strip_full = udp_base + vxdp_pkg::UDP_HDR_SIZE + vxdp_pkg::VXLAN_HDR_SIZE;
  assign et_full    = {ether_type_q[15:8], s1_byte_q};

  always_comb begin
    byte_index_d = (byte_index_q != 6'd63) ? byte_index_q + 6'd1 : byte_index_q;
    tag_count_d  = tag_count_q;
    ether_type_d = ether_type_q;
    ip_start_d   = ip_start_q;
    ip_proto_d   = ip_proto_q;
    dest_port_d  = dest_port_q;
    phase_d      = phase_q;
    case (phase_q)
      PH_ETH: begin
        if (pos == ip_base - 7'd2) begin
          ether_type_d = {s1_byte_q, 8'h00};
        end else if (pos == ip_base - 7'd1) begin
          ether_type_d = et_full;
          if (et_full == vxdp_pkg::ETYPE_CVLAN || et_full == vxdp_pkg::ETYPE_SVLAN) begin
            if ({30'd0, tag_count_q} < vxdp_pkg::MAX_VLAN_TAGS) begin
              tag_count_d = tag_count_q + 2'd1;
              ip_start_d  = ip_start_q + 5'd4;
            end else begin
              phase_d = PH_OTHER;
            end
          end else if (et_full == vxdp_pkg::ETYPE_IPV4) begin
            phase_d = PH_IP;
          end else begin
            phase_d = PH_OTHER;
          end
        end
      end
      PH_IP: begin
        if (pos == ip_base + 7'd9) begin
          ip_proto_d = s1_byte_q;
        end
        if (pos == udp_base - 7'd1) begin
          phase_d = (ip_proto_q == vxdp_pkg::PROTO_UDP) ? PH_UDP : PH_OTHER;
        end
      end
      PH_UDP: begin
        if (pos == udp_base + 7'd2) begin
          dest_port_d = {s1_byte_q, 8'h00};
        end else if (pos == udp_base + 7'd3) begin
          dest_port_d = {dest_port_q[15:8], s1_byte_q};
        end
        if (pos == udp_base + vxdp_pkg::UDP_HDR_SIZE - 7'd1) begin
          phase_d = (dest_port_q == vxlan_port_i) ? PH_VXLAN : PH_OTHER;
        end
      end
      PH_VXLAN: begin
        if (pos == strip_full - 7'd1) begin
          phase_d = PH_VXLAN_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.verdict      = 1'b0;
    res_o.is_vxlan     = 1'b0;
    res_o.strip_length = 6'd0;
    if (phase_d == PH_IP || phase_d == PH_VXLAN) begin
      res_o.verdict = 1'b1;
    end else if (phase_d == PH_VXLAN_OK) begin
      res_o.is_vxlan     = 1'b1;
      res_o.strip_length = strip_full[5:0];
    end
  end

  assign res_valid_o = s1_fire && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s1_byte_q    <= 8'd0;
      s1_last_q    <= 1'b0;
      byte_index_q <= 6'd0;
      tag_count_q  <= 2'd0;
      ether_type_q <= 16'd0;
      ip_start_q   <= vxdp_pkg::ETH_HDR_SIZE;
      ip_proto_q   <= 8'd0;
      dest_port_q  <= 16'd0;
      phase_q      <= PH_ETH;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_valid_q <= 1'b1;
        s1_byte_q  <= in_byte_i;
        s1_last_q  <= in_last_i;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        if (s1_last_q) begin
          byte_index_q <= 6'd0;
          tag_count_q  <= 2'd0;
          ether_type_q <= 16'd0;
          ip_start_q   <= vxdp_pkg::ETH_HDR_SIZE;
          ip_proto_q   <= 8'd0;
          dest_port_q  <= 16'd0;
          phase_q      <= PH_ETH;
        end else begin
          byte_index_q <= byte_index_d;
          tag_count_q  <= tag_count_d;
          ether_type_q <= ether_type_d;
          ip_start_q   <= ip_start_d;
          ip_proto_q   <= ip_proto_d;
          dest_port_q  <= dest_port_d;
          phase_q      <= phase_d;
        end
      end
    end
  end

endmodule

// ----- rtl/vxdp_out_reg.sv -----
// Result register that holds one decided item until the sink takes it.
module vxdp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  vxdp_pkg::result_t res_i,
  output logic              out_free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vxdp_pkg::result_t out_o
);

  logic              valid_q;
  vxdp_pkg::result_t res_q;

  assign out_free_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      res_q   <= '0;
    end else begin
      if (res_valid_i) begin
        valid_q <= 1'b1;
        res_q   <= res_i;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/vxlan_decap_header_parser.sv -----
// Top level of the VXLAN decapsulation header parser.
//
//   channel  direction  payload                              accepted when
//   in_i     input      packet_byte[7:0], last_byte          valid && ready
//   out_o    output     verdict, is_vxlan, strip_length[5:0] valid && ready
//   cfg      input      cfg_wdata_i[15:0] (vxlan_port)       cfg_we_i
//
// One byte is accepted every cycle unless a last byte waits on a stalled result register.
// The rate is set by the single input register feeding the parser and the result register.
// Reset clears all parse state and sets the VXLAN port to 4789.
// A stalled result holds the last byte of the next frame in the input register.
`include "vxlan_decap_header_parser_defines.svh"

module vxlan_decap_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  vxdp_in_if.sink     in_i,
  vxdp_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic              out_free;
  logic              res_valid;
  vxdp_pkg::result_t res;
  vxdp_pkg::result_t out_res;
  logic [15:0]       vxlan_port_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vxlan_port_q <= vxdp_pkg::VXLAN_PORT_RESET;
    end else if (cfg_we_i) begin
      vxlan_port_q <= cfg_wdata_i;
    end
  end

  vxdp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_byte_i    (in_i.packet_byte),
    .in_last_i    (in_i.last_byte),
    .vxlan_port_i (vxlan_port_q),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  vxdp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (out_res)
  );

  assign out_o.verdict      = out_res.verdict;
  assign out_o.is_vxlan     = out_res.is_vxlan;
  assign out_o.strip_length = out_res.strip_length;

  `VXDP_ASSERT_IMP(a_drop_clean, clk_i, rst_ni, out_o.valid && out_o.verdict,
                   !out_o.is_vxlan && out_o.strip_length == 6'd0,
                   "Dropped item carries strip data.")
  `VXDP_ASSERT_IMP(a_strip_len, clk_i, rst_ni, out_o.valid && out_o.is_vxlan,
                   out_o.strip_length == 6'd50 || out_o.strip_length == 6'd54 ||
                   out_o.strip_length == 6'd58,
                   "VXLAN strip length out of range.")
  `VXDP_ASSERT_NEXT(a_res_lands, clk_i, rst_ni, res_valid, out_o.valid,
                    "Decided item did not reach the result register.")

endmodule

// ----- dv/tb_vxlan_decap_header_parser.sv -----
`timescale 1ns / 1ps
// Testbench for the VXLAN decapsulation header parser: frame stimulus, parser prediction, checks.
module tb_vxlan_decap_header_parser;

  localparam int IP_LEN     = int'(vxdp_pkg::IPV4_HDR_SIZE);
  localparam int UDP_LEN    = int'(vxdp_pkg::UDP_HDR_SIZE);
  localparam int VXLAN_LEN  = int'(vxdp_pkg::VXLAN_HDR_SIZE);
  localparam int OUTER_BASE = int'(vxdp_pkg::ETH_HDR_SIZE) + IP_LEN + UDP_LEN + VXLAN_LEN;

  localparam logic [15:0] TYPE_IPV4 = vxdp_pkg::ETYPE_IPV4;
  localparam logic [7:0]  UDP_PROTO = vxdp_pkg::PROTO_UDP;

  typedef enum logic [2:0] {
    ST_ETH,
    ST_IPV4,
    ST_UDP,
    ST_VXLAN,
    ST_OTHER,
    ST_VXLAN_OK
  } parse_state_e;

  typedef logic [7:0] frame_t[$];

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  vxdp_in_if  in_ch ();
  vxdp_out_if out_ch ();

  vxlan_decap_header_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [15:0]  port_model;
  logic [5:0]   parse_index;
  logic [1:0]   parse_tags;
  logic [15:0]  parse_type;
  logic [4:0]   parse_ip_start;
  logic [7:0]   parse_proto;
  logic [15:0]  parse_dport;
  parse_state_e parse_phase;

  vxdp_pkg::result_t pending_verdicts[$];
  int                mismatch_count = 0;
  bit                idle_on = 1'b1;

  function automatic void clear_parser();
    parse_index    = '0;
    parse_tags     = '0;
    parse_type     = '0;
    parse_ip_start = vxdp_pkg::ETH_HDR_SIZE;
    parse_proto    = '0;
    parse_dport    = '0;
    parse_phase    = ST_ETH;
  endfunction

  // Advances the parser copy by one byte; returns 1 when the byte ends a frame.
  function automatic bit parse_byte(input logic [7:0] b, input logic lst,
                                    output vxdp_pkg::result_t r);
    int p;
    int ips;
    p   = int'(parse_index);
    ips = int'(parse_ip_start);
    r   = '0;
    if (parse_index < 6'd63) parse_index++;
    case (parse_phase)
      ST_ETH: begin
        if (p == ips - 2) begin
          parse_type = {b, 8'h00};
        end else if (p == ips - 1) begin
          parse_type = {parse_type[15:8], b};
          if (parse_type == vxdp_pkg::ETYPE_CVLAN || parse_type == vxdp_pkg::ETYPE_SVLAN) begin
            if (parse_tags < vxdp_pkg::MAX_VLAN_TAGS) begin
              parse_tags++;
              parse_ip_start += 5'd4;
            end else begin
              parse_phase = ST_OTHER;
            end
          end else if (parse_type == TYPE_IPV4) begin
            parse_phase = ST_IPV4;
          end else begin
            parse_phase = ST_OTHER;
          end
        end
      end
      ST_IPV4: begin
        if (p == ips + 9) parse_proto = b;
        if (p == ips + IP_LEN - 1) begin
          parse_phase = (parse_proto == UDP_PROTO) ? ST_UDP : ST_OTHER;
        end
      end
      ST_UDP: begin
        if (p == ips + IP_LEN + 2) parse_dport = {b, 8'h00};
        else if (p == ips + IP_LEN + 3) parse_dport = {parse_dport[15:8], b};
        if (p == ips + IP_LEN + UDP_LEN - 1) begin
          parse_phase = (parse_dport == port_model) ? ST_VXLAN : ST_OTHER;
        end
      end
      ST_VXLAN: begin
        if (p == ips + IP_LEN + UDP_LEN + VXLAN_LEN - 1) parse_phase = ST_VXLAN_OK;
      end
      default: begin
      end
    endcase
    if (!lst) return 1'b0;
    if (parse_phase == ST_IPV4 || parse_phase == ST_VXLAN) begin
      r.verdict = 1'b1;
    end else if (parse_phase == ST_VXLAN_OK) begin
      r.is_vxlan     = 1'b1;
      r.strip_length = 6'(int'(parse_ip_start) + IP_LEN + UDP_LEN + VXLAN_LEN);
    end
    clear_parser();
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int                gap;
    vxdp_pkg::result_t r;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.packet_byte <= b;
    in_ch.last_byte   <= lst;
    do @(posedge clk_i); while (!in_ch.ready);
    if (parse_byte(b, lst, r)) pending_verdicts.push_back(r);
  endtask

  task automatic send_frame(input frame_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_vxlan_port(input logic [15:0] value);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    port_model = value;
  endtask

  // Builds Ethernet, tags, IPv4, UDP and VXLAN headers, then cuts or pads to len bytes.
  task automatic build_frame(input int n_tags, input logic [15:0] l3_type,
                             input logic [7:0] proto, input logic [15:0] dport,
                             input int len, output frame_t f);
    logic [15:0] tag;
    f = {};
    repeat (12) f.push_back(8'($urandom));
    repeat (n_tags) begin
      tag = $urandom_range(0, 1) ? vxdp_pkg::ETYPE_CVLAN : vxdp_pkg::ETYPE_SVLAN;
      f.push_back(tag[15:8]);
      f.push_back(tag[7:0]);
      repeat (2) f.push_back(8'($urandom));
    end
    f.push_back(l3_type[15:8]);
    f.push_back(l3_type[7:0]);
    for (int i = 0; i < IP_LEN; i++) f.push_back(i == 9 ? proto : 8'($urandom));
    for (int i = 0; i < UDP_LEN; i++) begin
      if (i == 2) f.push_back(dport[15:8]);
      else if (i == 3) f.push_back(dport[7:0]);
      else f.push_back(8'($urandom));
    end
    repeat (VXLAN_LEN) f.push_back(8'($urandom));
    while (f.size() < len) f.push_back(8'($urandom));
    while (f.size() > len) void'(f.pop_back());
  endtask

  task automatic test_directed_frames();
    frame_t f;
    build_frame(0, TYPE_IPV4, UDP_PROTO, port_model, 1, f);
    send_frame(f);
    build_frame(1, TYPE_IPV4, UDP_PROTO, port_model, 16, f);
    send_frame(f);
    build_frame(0, TYPE_IPV4, UDP_PROTO, port_model, 14, f);
    send_frame(f);
    build_frame(0, 16'h86DD, UDP_PROTO, port_model, 40, f);
    send_frame(f);
    build_frame(3, TYPE_IPV4, UDP_PROTO, port_model, 70, f);
    send_frame(f);
    build_frame(0, TYPE_IPV4, UDP_PROTO, port_model, 20, f);
    send_frame(f);
    build_frame(0, TYPE_IPV4, 8'd6, port_model, 60, f);
    send_frame(f);
    build_frame(0, TYPE_IPV4, UDP_PROTO, port_model, 38, f);
    send_frame(f);
    build_frame(0, TYPE_IPV4, UDP_PROTO, port_model + 16'd1, 60, f);
    send_frame(f);
    build_frame(1, TYPE_IPV4, UDP_PROTO, port_model, 45, f);
    send_frame(f);
    build_frame(0, TYPE_IPV4, UDP_PROTO, port_model, OUTER_BASE, f);
    send_frame(f);
    build_frame(2, TYPE_IPV4, UDP_PROTO, port_model, OUTER_BASE + 8, f);
    send_frame(f);
    build_frame(1, TYPE_IPV4, UDP_PROTO, port_model, 100, f);
    send_frame(f);
    foreach (f[i]) f[i] = 8'h00;
    send_frame(f);
    foreach (f[i]) f[i] = 8'hFF;
    send_frame(f);
  endtask

  task automatic test_port_extremes();
    frame_t f;
    logic [15:0] ports[2];
    ports[0] = 16'h0000;
    ports[1] = 16'hFFFF;
    foreach (ports[k]) begin
      write_vxlan_port(ports[k]);
      build_frame(0, TYPE_IPV4, UDP_PROTO, ports[k], OUTER_BASE + 3, f);
      send_frame(f);
      build_frame(1, TYPE_IPV4, UDP_PROTO, vxdp_pkg::VXLAN_PORT_RESET, OUTER_BASE + 4, f);
      send_frame(f);
      build_frame(2, TYPE_IPV4, UDP_PROTO, ports[k], OUTER_BASE + 8, f);
      send_frame(f);
    end
  endtask

  // Well-formed VXLAN frames with random content, mixed with near misses and noise.
  task automatic test_random_frames(input int byte_target);
    frame_t      f;
    int          bytes_sent;
    int          frames_sent;
    int          n_tags;
    int          full;
    int          len;
    logic [15:0] l3_type;
    logic [7:0]  proto;
    logic [15:0] dport;
    bytes_sent  = 0;
    frames_sent = 0;
    while (bytes_sent < byte_target || frames_sent < 4) begin
      n_tags  = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(0, 2);
      full    = OUTER_BASE + 4 * n_tags;
      l3_type = TYPE_IPV4;
      proto   = UDP_PROTO;
      dport   = port_model;
      case ($urandom_range(0, 9))
        0: l3_type = 16'($urandom);
        1: proto = 8'($urandom);
        2: dport = 16'($urandom);
        default: begin
        end
      endcase
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, full) : full + $urandom_range(0, 12);
      build_frame(n_tags, l3_type, proto, dport, len, f);
      if ($urandom_range(0, 9) == 0) begin
        foreach (f[i]) f[i] = 8'($urandom);
      end
      if ($urandom_range(0, 7) == 0) idle_on = !idle_on;
      send_frame(f);
      if ($urandom_range(0, 9) == 0) wait_for_results();
      bytes_sent += f.size();
      frames_sent++;
    end
  endtask

  initial begin
    int                stall;
    vxdp_pkg::result_t want;
    stall        = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: result with none expected, got verdict %0d is_vxlan %0d strip %0d",
                   $time, out_ch.verdict, out_ch.is_vxlan, out_ch.strip_length);
          mismatch_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_ch.verdict !== want.verdict) begin
            $display("%0t: verdict expected %0d got %0d", $time, want.verdict, out_ch.verdict);
            mismatch_count++;
          end
          if (out_ch.is_vxlan !== want.is_vxlan) begin
            $display("%0t: is_vxlan expected %0d got %0d", $time, want.is_vxlan,
                     out_ch.is_vxlan);
            mismatch_count++;
          end
          if (out_ch.strip_length !== want.strip_length) begin
            $display("%0t: strip_length expected %0d got %0d", $time, want.strip_length,
                     out_ch.strip_length);
            mismatch_count++;
          end
        end
        stall = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #400000;
    $display("tb_vxlan_decap_header_parser: FAIL");
    $finish;
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.packet_byte = 8'h00;
    in_ch.last_byte   = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = 16'h0000;
    port_model        = vxdp_pkg::VXLAN_PORT_RESET;
    clear_parser();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_frames();
    test_port_extremes();
    write_vxlan_port(vxdp_pkg::VXLAN_PORT_RESET);
    test_random_frames(350);
    write_vxlan_port(16'($urandom));
    test_random_frames(360);
    wait_for_results();
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_vxlan_decap_header_parser: PASS");
    end else begin
      $display("tb_vxlan_decap_header_parser: FAIL");
    end
    $finish;
  end

endmodule

// ----- vxlan_decap_header_parser.f -----
+incdir+rtl
rtl/vxdp_pkg.sv
rtl/vxdp_if.sv
rtl/vxdp_parse.sv
rtl/vxdp_out_reg.sv
rtl/vxlan_decap_header_parser.sv
dv/tb_vxlan_decap_header_parser.sv
